FILE: sv/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

  localparam int unsigned DEFAULT_LENGTH_BITS = 64;

  localparam logic [3:0] POS_START   = 4'd0;
  localparam logic [3:0] POS_LEN     = 4'd1;
  localparam logic [3:0] POS_PAYLOAD = 4'd14;
  localparam logic [3:0] POS_DRAIN   = 4'd15;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] HDR_BASE  = 4'd2;
  localparam logic [3:0] EXT_NONE  = 4'd0;
  localparam logic [3:0] EXT_16    = 4'd2;
  localparam logic [3:0] EXT_64    = 4'd8;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       last_of_payload;
  } result_t;

endpackage

FILE: sv/wsd_in_if.sv
// Input channel of the deframer: one received byte per beat.
// No dependencies.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source(output valid, output data_byte, output end_of_buffer, input ready);
  modport sink(input valid, input data_byte, input end_of_buffer, output ready);
endinterface

FILE: sv/wsd_out_if.sv
// Output channel of the deframer: one result per beat.
// No dependencies.
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic       last_of_payload;

  modport source(output valid, output result_kind, output payload_byte,
                 output last_of_payload, input ready);
  modport sink(input valid, input result_kind, input payload_byte,
               input last_of_payload, output ready);
endinterface

FILE: sv/wsd_in_stage.sv
// Input register of the deframer: captures one beat from the input channel.
// Depends on wsd_pkg and wsd_in_if.
module wsd_in_stage (
  input  logic              clk,
  input  logic              rst,
  wsd_in_if.sink            in_ch,
  input  logic              advance,
  output logic              beat_valid,
  output wsd_pkg::in_beat_t beat
);
  import wsd_pkg::*;

  assign in_ch.ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ch.ready) begin
      beat_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      beat.data_byte     <= in_ch.data_byte;
      beat.end_of_buffer <= in_ch.end_of_buffer;
    end
  end
endmodule

FILE: sv/wsd_parser.sv
// Frame header parser and payload unmasking; holds the per-frame state.
// Depends on wsd_pkg.
module wsd_parser #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  wsd_pkg::in_beat_t beat,
  output logic              res_valid,
  output wsd_pkg::result_t  res
);
  import wsd_pkg::*;

  logic [3:0]             pos, pos_next;
  logic [3:0]             opcode, opcode_next;
  logic                   mask_present, mask_present_next;
  logic [6:0]             length_code, length_code_next;
  logic [LENGTH_BITS-1:0] len, len_next;
  logic                   len_ovf, len_ovf_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [LENGTH_BITS-1:0] idx, idx_next;

  logic [3:0]             ext_cur, ext_next, need, pos_inc;
  logic [7:0]             key_byte;
  logic                   fin;

  always_comb begin
    case (length_code)
      LEN_CODE_16: ext_cur = EXT_16;
      LEN_CODE_64: ext_cur = EXT_64;
      default:     ext_cur = EXT_NONE;
    endcase
    case (length_code_next)
      LEN_CODE_16: ext_next = EXT_16;
      LEN_CODE_64: ext_next = EXT_64;
      default:     ext_next = EXT_NONE;
    endcase
  end

  always_comb begin
    case (idx[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    if (!mask_present) key_byte = 8'h00;
  end

  assign fin     = (idx + 1'b1) == len;
  assign pos_inc = pos + 4'd1;
  assign need    = HDR_BASE + ext_next + (mask_present_next ? KEY_BYTES : EXT_NONE);

  always_comb begin
    pos_next          = pos;
    opcode_next       = opcode;
    mask_present_next = mask_present;
    length_code_next  = length_code;
    len_next          = len;
    len_ovf_next      = len_ovf;
    mask_key_next     = mask_key;
    idx_next          = idx;
    res_valid         = 1'b0;
    res               = '0;

    if (pos == POS_DRAIN) begin
      pos_next = POS_DRAIN;
    end else if (pos == POS_PAYLOAD) begin
      res_valid           = 1'b1;
      res.result_kind     = KIND_TEXT;
      res.payload_byte    = beat.data_byte ^ key_byte;
      res.last_of_payload = fin || beat.end_of_buffer;
      idx_next            = idx + 1'b1;
      if (fin) pos_next = POS_DRAIN;
    end else begin
      if (pos == POS_START) begin
        opcode_next       = beat.data_byte[3:0];
        mask_present_next = 1'b0;
        length_code_next  = '0;
        len_next          = '0;
        len_ovf_next      = 1'b0;
        mask_key_next     = '0;
        idx_next          = '0;
      end else if (pos == POS_LEN) begin
        mask_present_next = beat.data_byte[7];
        length_code_next  = beat.data_byte[6:0];
        len_next          = (beat.data_byte[6:0] < LEN_CODE_16) ?
                            LENGTH_BITS'(beat.data_byte[6:0]) : '0;
      end else if (pos < HDR_BASE + ext_cur) begin
        len_next     = {len[LENGTH_BITS-9:0], beat.data_byte};
        len_ovf_next = len_ovf || (|len[LENGTH_BITS-1:LENGTH_BITS-8]);
      end else begin
        mask_key_next = {mask_key[23:0], beat.data_byte};
      end
      pos_next = pos_inc;
      if (pos_inc >= HDR_BASE && pos_inc == need) begin
        if (len_ovf_next) len_next = '1;
        idx_next = '0;
        if (opcode_next == OP_CLOSE) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_CLOSE;
          pos_next        = POS_DRAIN;
        end else if (opcode_next == OP_TEXT && len_next != '0) begin
          pos_next = POS_PAYLOAD;
        end else begin
          pos_next = POS_DRAIN;
        end
      end else if (beat.end_of_buffer) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_SHORT;
      end
    end

    if (beat.end_of_buffer) pos_next = POS_START;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= POS_START;
      opcode       <= '0;
      mask_present <= 1'b0;
      length_code  <= '0;
      len          <= '0;
      len_ovf      <= 1'b0;
      mask_key     <= '0;
      idx          <= '0;
    end else if (fire) begin
      pos          <= pos_next;
      opcode       <= opcode_next;
      mask_present <= mask_present_next;
      length_code  <= length_code_next;
      len          <= len_next;
      len_ovf      <= len_ovf_next;
      mask_key     <= mask_key_next;
      idx          <= idx_next;
    end
  end

`ifndef SYNTHESIS
  a_payload_nonempty: assert property (@(posedge clk) disable iff (rst)
    pos == POS_PAYLOAD |-> len != '0)
    else $error("payload state with zero length");
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    pos == POS_PAYLOAD |-> idx < len)
    else $error("payload index past frame length");
  a_eob_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && beat.end_of_buffer |=> pos == POS_START)
    else $error("parser did not restart after buffer end");
  a_text_from_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind == KIND_TEXT |-> pos == POS_PAYLOAD)
    else $error("text byte emitted outside payload");
  a_nontext_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind != KIND_TEXT |->
      res.payload_byte == 8'h00 && !res.last_of_payload)
    else $error("non-text result carries payload fields");
`endif
endmodule

FILE: sv/wsd_out_stage.sv
// Result register of the deframer: holds one result until the sink takes it.
// Depends on wsd_pkg and wsd_out_if.
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             res_valid,
  input  wsd_pkg::result_t res,
  output logic             advance,
  wsd_out_if.source        out_ch
);
  import wsd_pkg::*;

  logic    valid;
  result_t held;

  assign advance = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) held <= res;
  end

  assign out_ch.valid           = valid;
  assign out_ch.result_kind     = held.result_kind;
  assign out_ch.payload_byte    = held.payload_byte;
  assign out_ch.last_of_payload = held.last_of_payload;
endmodule

FILE: sv/websocket_frame_deframer.sv
// WebSocket frame deframer: takes one byte per beat, at most one result per beat.
// Top level; depends on wsd_pkg, wsd_in_if, wsd_out_if, wsd_in_stage,
// wsd_parser and wsd_out_stage.
//
// One byte is accepted every cycle while the result register is free or being
// drained; each byte passes through an input register, one pass of header
// parsing and payload unmasking, and a result register. Every buffer holds one
// frame; text payload bytes come out unmasked with the last one flagged, a close
// frame gives one close result, and a buffer that ends inside its header gives a
// short-frame result. Lengths wider than LENGTH_BITS saturate. No clearing pass
// after reset.
module websocket_frame_deframer #(
  parameter int unsigned LENGTH_BITS = wsd_pkg::DEFAULT_LENGTH_BITS
) (
  input logic       clk,
  input logic       rst,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);
  import wsd_pkg::*;

  logic     beat_valid;
  in_beat_t beat;
  logic     advance;
  logic     fire;
  logic     res_valid;
  result_t  res;

  assign fire = beat_valid && advance;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (advance),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_ch    (out_ch)
  );
endmodule
